@@ rtl/core/bcs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the semaphore unit.
package bcs_pkg;

    localparam int COUNT_W   = 16;
    localparam int ID_W      = 8;
    localparam int QDEPTH    = 16;
    localparam int QIDX_W    = 4;
    localparam int QFILL_W   = 5;
    localparam int ENTRY_W   = ID_W + COUNT_W;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // Request types.
    localparam logic REQ_WAIT   = 1'b0;
    localparam logic REQ_SIGNAL = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAKE_WAITER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WAKE_SIGNALER = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 1'b1;

    typedef struct packed {
        logic load_req;
        logic exec_req;
        logic drain;
    } bcs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
    } bcs_status_t;

endpackage

@@ rtl/core/bounded_counting_semaphore_unit.sv @@
// Top level of the bounded counting semaphore unit.
// Each input word is a wait or signal request; the unit answers with one result word
// for the request itself, followed by one word per thread woken from the opposite
// queue, the final word of a request marked by tlast. A request that wakes nobody
// holds the input through an accept step and a step that forms its result word.
// Each woken thread adds a drain step; every one after the first also adds a fetch
// step before it, since each wake-up pops the queue head and the registered queue
// read must follow it. A result word the receiver has not yet taken holds the next step
// until it is taken. The next request is accepted once the previous one has handed its
// last word to the result register.
// Writing initial_count loads the count and empties both 16-entry queues.
module bounded_counting_semaphore_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: requester_id[7:0], amount[23:8].
    input  logic [bcs_pkg::S_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: req_type[0].
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: thread_ref[7:0], granted[23:8].
    output logic [bcs_pkg::M_DATA_W-1:0]      m_tdata,
    // Fields from bit 0: result_kind[2:0].
    output logic [bcs_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bcs_pkg::*;

    bcs_cmd_t            cmd;
    bcs_status_t         status;
    logic [ID_W-1:0]     res_thread;
    logic [COUNT_W-1:0]  res_granted;

    bcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bcs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .req_type    (s_tuser),
        .req_id      (s_tdata[ID_W-1:0]),
        .req_amount  (s_tdata[ID_W+COUNT_W-1:ID_W]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_kind    (m_tuser),
        .res_thread  (res_thread),
        .res_granted (res_granted),
        .res_last    (m_tlast)
    );

    assign m_tdata = {res_granted, res_thread};

endmodule

@@ rtl/core/bcs_datapath.sv @@
// Datapath: request register, count, both wait queues and the result register.
module bcs_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bcs_pkg::bcs_cmd_t            cmd,
    output bcs_pkg::bcs_status_t         status,
    input  logic                         req_type,
    input  logic [bcs_pkg::ID_W-1:0]     req_id,
    input  logic [bcs_pkg::COUNT_W-1:0]  req_amount,
    input  logic                         cfg_we,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [bcs_pkg::KIND_W-1:0]   res_kind,
    output logic [bcs_pkg::ID_W-1:0]     res_thread,
    output logic [bcs_pkg::COUNT_W-1:0]  res_granted,
    output logic                         res_last
);
    import bcs_pkg::*;

    localparam logic [QFILL_W-1:0] QFULL = QFILL_W'(QDEPTH);

    logic                 type_reg;
    logic [ID_W-1:0]      id_reg;
    logic [COUNT_W-1:0]   amt_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   max_reg;

    logic [ENTRY_W-1:0]   wq_mem [QDEPTH];
    logic [ENTRY_W-1:0]   sq_mem [QDEPTH];
    logic [ENTRY_W-1:0]   w_rd_reg, s_rd_reg;
    logic [QIDX_W-1:0]    w_head_reg, s_head_reg;
    logic [QFILL_W-1:0]   w_fill_reg, s_fill_reg;
    logic [QIDX_W-1:0]    w_tail, s_tail;

    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [COUNT_W-1:0]   out_granted_reg;
    logic                 out_last_reg;

    logic [COUNT_W-1:0]   cap;
    logic [COUNT_W-1:0]   room;
    logic [COUNT_W-1:0]   pop_amt;
    logic [ID_W-1:0]      pop_id;
    logic                 push_w, push_s, pop_w, pop_s;
    logic [KIND_W-1:0]    kind_c;
    logic [ID_W-1:0]      id_c;
    logic [COUNT_W-1:0]   granted_c;
    logic                 last_c;

    assign cap    = (max_reg != '0) ? max_reg : '1;
    assign w_tail = w_head_reg + w_fill_reg[QIDX_W-1:0];
    assign s_tail = s_head_reg + s_fill_reg[QIDX_W-1:0];

    // A wait request drains the signaler queue; a signal drains the waiter queue.
    always_comb begin
        count_next = count_reg;
        push_w     = 1'b0;
        push_s     = 1'b0;
        pop_w      = 1'b0;
        pop_s      = 1'b0;
        kind_c     = KIND_DONE;
        id_c       = id_reg;
        granted_c  = '0;
        last_c     = 1'b1;
        room       = '0;
        pop_amt    = '0;
        pop_id     = '0;
        if (cmd.exec_req) begin
            if (type_reg == REQ_WAIT) begin
                if (count_reg != '0) begin
                    granted_c  = (amt_reg != '0 && count_reg > amt_reg) ? amt_reg : count_reg;
                    count_next = count_reg - granted_c;
                end else if (w_fill_reg < QFULL) begin
                    push_w = 1'b1;
                    kind_c = KIND_QUEUED;
                end else begin
                    kind_c = KIND_REJECTED;
                end
                last_c = !(count_next < cap && s_fill_reg != '0);
            end else begin
                if (max_reg != '0 && count_reg >= max_reg) begin
                    if (s_fill_reg < QFULL) begin
                        push_s = 1'b1;
                        kind_c = KIND_QUEUED;
                    end else begin
                        kind_c = KIND_REJECTED;
                    end
                end else begin
                    room       = (count_reg < cap) ? cap - count_reg : '0;
                    granted_c  = (amt_reg > room) ? room : amt_reg;
                    count_next = count_reg + granted_c;
                end
                last_c = !(count_next != '0 && w_fill_reg != '0);
            end
        end else if (cmd.drain) begin
            if (type_reg == REQ_WAIT) begin
                pop_s      = 1'b1;
                pop_amt    = s_rd_reg[COUNT_W-1:0];
                pop_id     = s_rd_reg[ENTRY_W-1:COUNT_W];
                room       = cap - count_reg;
                granted_c  = (pop_amt != '0 && pop_amt < room) ? pop_amt : room;
                count_next = count_reg + granted_c;
                kind_c     = KIND_WAKE_SIGNALER;
                id_c       = pop_id;
                last_c     = !(count_next < cap && s_fill_reg > QFILL_W'(1));
            end else begin
                pop_w      = 1'b1;
                pop_amt    = w_rd_reg[COUNT_W-1:0];
                pop_id     = w_rd_reg[ENTRY_W-1:COUNT_W];
                granted_c  = (pop_amt != '0 && count_reg > pop_amt) ? pop_amt : count_reg;
                count_next = count_reg - granted_c;
                kind_c     = KIND_WAKE_WAITER;
                id_c       = pop_id;
                last_c     = !(count_next != '0 && w_fill_reg > QFILL_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            max_reg    <= '0;
            w_head_reg <= '0;
            w_fill_reg <= '0;
            s_head_reg <= '0;
            s_fill_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_INITIAL_COUNT) begin
                count_reg  <= cfg_wdata;
                w_head_reg <= '0;
                w_fill_reg <= '0;
                s_head_reg <= '0;
                s_fill_reg <= '0;
            end else begin
                max_reg <= cfg_wdata;
            end
        end else begin
            count_reg <= count_next;
            if (push_w) begin
                w_fill_reg <= w_fill_reg + QFILL_W'(1);
            end else if (pop_w) begin
                w_fill_reg <= w_fill_reg - QFILL_W'(1);
                w_head_reg <= w_head_reg + QIDX_W'(1);
            end
            if (push_s) begin
                s_fill_reg <= s_fill_reg + QFILL_W'(1);
            end else if (pop_s) begin
                s_fill_reg <= s_fill_reg - QFILL_W'(1);
                s_head_reg <= s_head_reg + QIDX_W'(1);
            end
        end
    end

    // Queue storage with registered head reads.
    always_ff @(posedge aclk) begin
        if (push_w) begin
            wq_mem[w_tail] <= {id_reg, amt_reg};
        end
        if (push_s) begin
            sq_mem[s_tail] <= {id_reg, amt_reg};
        end
        w_rd_reg <= wq_mem[w_head_reg];
        s_rd_reg <= sq_mem[s_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            type_reg <= req_type;
            id_reg   <= req_id;
            amt_reg  <= req_amount;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec_req || cmd.drain) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec_req || cmd.drain) begin
            out_kind_reg    <= kind_c;
            out_id_reg      <= id_c;
            out_granted_reg <= granted_c;
            out_last_reg    <= last_c;
        end
    end

    assign status = '{out_free: (!out_valid_reg || res_ready), more: !last_c};

    assign res_valid   = out_valid_reg;
    assign res_kind    = out_kind_reg;
    assign res_thread  = out_id_reg;
    assign res_granted = out_granted_reg;
    assign res_last    = out_last_reg;

endmodule

@@ rtl/core/bcs_ctrl.sv @@
// Controller: sequences request intake, the request result and the queue drain.
module bcs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bcs_pkg::bcs_status_t  status,
    output bcs_pkg::bcs_cmd_t     cmd
);
    import bcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FETCH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec_req = 1'b1;
                    state_next   = status.more ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (status.out_free) begin
                    cmd.drain  = 1'b1;
                    state_next = status.more ? ST_FETCH : ST_IDLE;
                end
            end
            // The head pointer just moved; the registered queue read must follow it before the next drain.
            ST_FETCH: begin
                state_next = ST_DRAIN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ verif/bounded_counting_semaphore_unit_test.sv @@
// Self-checking testbench for the bounded counting semaphore unit.
module bounded_counting_semaphore_unit_test;
    import bcs_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_WORDS = 55;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   id;
        logic [COUNT_W-1:0] amount;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    thread;
        logic [COUNT_W-1:0] granted;
        logic               last;
    } outcome_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] amount;
    } parked_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        request_t             rq;
        int                   reps;
        bit                   typed;
        logic [KIND_W-1:0]    exp_kind;
        logic [COUNT_W-1:0]   exp_granted;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predicted semaphore state.
    logic [COUNT_W-1:0] sem_count;
    logic [COUNT_W-1:0] sem_cap;
    parked_t            waiting_threads[$];
    parked_t            signaling_threads[$];
    outcome_t           fresh[$];
    outcome_t           expected_results[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int idle_plan[4]  = '{0, 79, 0, 19};
    int stall_plan[4] = '{0, 0, 79, 19};
    logic [COUNT_W-1:0] init_set[8] = '{16'd0, 16'hFFFF, 16'd4, 16'd0,
                                        16'hFFFF, 16'd30, 16'd0, 16'd0};
    logic [COUNT_W-1:0] max_set[8]  = '{16'd0, 16'd0, 16'd8, 16'd1,
                                        16'hFFFF, 16'd6, 16'd0, 16'd3};

    bounded_counting_semaphore_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [COUNT_W-1:0] cap_limit();
        return (sem_cap != '0) ? sem_cap : '1;
    endfunction

    function automatic void note(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [COUNT_W-1:0] given);
        fresh.push_back(outcome_t'{kind, id, given, 1'b0});
    endfunction

    // Works out every word one request produces and advances the semaphore state.
    function automatic void predict_request(input request_t r);
        logic [COUNT_W-1:0] take;
        logic [COUNT_W-1:0] room;
        parked_t            e;
        fresh.delete();
        if (r.req_type == REQ_WAIT) begin
            if (sem_count != '0) begin
                take = (r.amount != '0 && sem_count > r.amount) ? r.amount : sem_count;
                sem_count -= take;
                note(KIND_DONE, r.id, take);
            end else if (waiting_threads.size() < QDEPTH) begin
                waiting_threads.push_back(parked_t'{r.id, r.amount});
                note(KIND_QUEUED, r.id, '0);
            end else begin
                note(KIND_REJECTED, r.id, '0);
            end
            // Parked signalers refill the count in arrival order while there is room.
            while (sem_count < cap_limit() && signaling_threads.size() != 0) begin
                e = signaling_threads.pop_front();
                room = cap_limit() - sem_count;
                take = (e.amount != '0 && e.amount < room) ? e.amount : room;
                sem_count += take;
                note(KIND_WAKE_SIGNALER, e.id, take);
            end
        end else begin
            if (sem_cap != '0 && sem_count >= sem_cap) begin
                if (signaling_threads.size() < QDEPTH) begin
                    signaling_threads.push_back(parked_t'{r.id, r.amount});
                    note(KIND_QUEUED, r.id, '0);
                end else begin
                    note(KIND_REJECTED, r.id, '0);
                end
            end else begin
                room = cap_limit() - sem_count;
                take = (r.amount > room) ? room : r.amount;
                sem_count += take;
                note(KIND_DONE, r.id, take);
            end
            while (sem_count != '0 && waiting_threads.size() != 0) begin
                e = waiting_threads.pop_front();
                take = (e.amount != '0 && sem_count > e.amount) ? e.amount : sem_count;
                sem_count -= take;
                note(KIND_WAKE_WAITER, e.id, take);
            end
        end
        fresh[fresh.size()-1].last = 1'b1;
    endfunction

    function automatic plan_row_t request_row(input logic t, input logic [ID_W-1:0] id,
                                              input logic [COUNT_W-1:0] amt, input int reps,
                                              input bit typed, input logic [KIND_W-1:0] k,
                                              input logic [COUNT_W-1:0] g);
        plan_row_t row;
        row.is_reg      = 1'b0;
        row.reg_idx     = REG_INITIAL_COUNT;
        row.rq          = request_t'{t, id, amt};
        row.reps        = reps;
        row.typed       = typed;
        row.exp_kind    = k;
        row.exp_granted = g;
        return row;
    endfunction

    function automatic plan_row_t register_row(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [COUNT_W-1:0] val);
        plan_row_t row;
        row = request_row(REQ_WAIT, '0, val, 1, 1'b0, KIND_DONE, '0);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input request_t r, input bit typed,
                                input logic [KIND_W-1:0] k, input logic [COUNT_W-1:0] g);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.amount, r.id};
        s_tuser  <= r.req_type;
        do @(posedge aclk); while (!s_tready);
        predict_request(r);
        if (typed) begin
            fresh[0].kind    = k;
            fresh[0].granted = g;
        end
        foreach (fresh[i]) expected_results.push_back(fresh[i]);
        @(negedge aclk);
    endtask

    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_INITIAL_COUNT) begin
            sem_count = val;
            waiting_threads.delete();
            signaling_threads.delete();
        end else begin
            sem_cap = val;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("kind of a word with nothing expected", m_tuser, -1);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.kind)
                    flag_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[7:0] != want.thread)
                    flag_mismatch("thread_ref", m_tdata[7:0], want.thread);
                if (m_tdata[23:8] != want.granted)
                    flag_mismatch("granted", m_tdata[23:8], want.granted);
                if (m_tlast != want.last)
                    flag_mismatch("tlast", m_tlast, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[bounded_counting_semaphore_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial begin
        plan_row_t plan[$];
        request_t  r;
        int        wait_pct;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_INITIAL_COUNT;
        cfg_wdata = '0;
        sem_count = '0;
        sem_cap   = '0;

        // Unbounded after reset: a parked waiter, saturation and take-all.
        plan.push_back(request_row(REQ_WAIT,   8'h00, 16'd5,    1, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_SIGNAL, 8'hFF, 16'hFFFF, 1, 1, KIND_DONE, 16'hFFFF));
        plan.push_back(request_row(REQ_SIGNAL, 8'h12, 16'd100,  1, 1, KIND_DONE, 16'd5));
        plan.push_back(request_row(REQ_WAIT,   8'h34, 16'd0,    1, 1, KIND_DONE, 16'hFFFF));
        plan.push_back(request_row(REQ_SIGNAL, 8'h35, 16'd0,    1, 1, KIND_DONE, 16'd0));
        // Capped at 12: clipping, parked signalers, wake-ups after a big wait.
        plan.push_back(register_row(REG_INITIAL_COUNT, 16'd10));
        plan.push_back(register_row(REG_MAX_COUNT, 16'd12));
        plan.push_back(request_row(REQ_SIGNAL, 8'h01, 16'd5,  1, 1, KIND_DONE, 16'd2));
        plan.push_back(request_row(REQ_SIGNAL, 8'h07, 16'd3,  1, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_SIGNAL, 8'h08, 16'd0,  1, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_WAIT,   8'h09, 16'd20, 1, 1, KIND_DONE, 16'd12));
        // Cap lowered below the count.
        plan.push_back(register_row(REG_MAX_COUNT, 16'd5));
        plan.push_back(request_row(REQ_SIGNAL, 8'h0A, 16'd1,  1, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_WAIT,   8'h0B, 16'd3,  1, 1, KIND_DONE, 16'd3));
        plan.push_back(request_row(REQ_WAIT,   8'h0C, 16'd9,  1, 1, KIND_DONE, 16'd9));
        // Full waiter queue, a rejected wait, then one signal waking all sixteen.
        plan.push_back(register_row(REG_MAX_COUNT, 16'd0));
        plan.push_back(register_row(REG_INITIAL_COUNT, 16'd0));
        plan.push_back(request_row(REQ_WAIT,   8'h40, 16'd1,    16, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_WAIT,   8'h80, 16'd7,    1, 1, KIND_REJECTED, 16'd0));
        plan.push_back(request_row(REQ_SIGNAL, 8'h81, 16'hFFFF, 1, 1, KIND_DONE, 16'hFFFF));
        // Both registers at their top value.
        plan.push_back(register_row(REG_MAX_COUNT, 16'hFFFF));
        plan.push_back(register_row(REG_INITIAL_COUNT, 16'hFFFF));
        plan.push_back(request_row(REQ_SIGNAL, 8'hC1, 16'd1,    1, 1, KIND_QUEUED, 16'd0));
        plan.push_back(request_row(REQ_WAIT,   8'hC0, 16'hFFFF, 1, 1, KIND_DONE, 16'hFFFF));

        init_set[6] = COUNT_W'($urandom_range(0, 65535));
        max_set[6]  = COUNT_W'($urandom_range(1, 20));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[p]) begin
            if (plan[p].is_reg) begin
                wait_for_quiet();
                write_reg(plan[p].reg_idx, plan[p].rq.amount);
            end else begin
                for (int i = 0; i < plan[p].reps; i++) begin
                    r = plan[p].rq;
                    r.id = r.id + ID_W'(i);
                    send_request(r, plan[p].typed, plan[p].exp_kind, plan[p].exp_granted);
                end
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_for_quiet();
            sender_idle_pct    = idle_plan[phase/2];
            receiver_stall_pct = stall_plan[phase/2];
            write_reg(REG_MAX_COUNT, max_set[phase]);
            write_reg(REG_INITIAL_COUNT, init_set[phase]);
            wait_pct = $urandom_range(30, 70);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Let the unit run dry once in the middle of every phase.
                if (n == PHASE_WORDS / 2)
                    wait_for_quiet();
                r.req_type = ($urandom_range(0, 99) < wait_pct) ? REQ_WAIT : REQ_SIGNAL;
                r.id       = ID_W'($urandom);
                case ($urandom_range(0, 15))
                    0:       r.amount = '0;
                    1:       r.amount = '1;
                    2:       r.amount = COUNT_W'($urandom);
                    default: r.amount = COUNT_W'($urandom_range(1, 12));
                endcase
                send_request(r, 1'b0, KIND_DONE, '0);
            end
        end

        wait_for_quiet();
        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("[bounded_counting_semaphore_unit] OK");
        else
            $display("[bounded_counting_semaphore_unit] ERROR");
        $finish;
    end

endmodule
